@@ rtl/core/assert_macros.svh @@
// assertion macros shared by the deque rtl
// no dependencies; expects clk_i and rst_ni in the using module

`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// checked property, disabled while reset is held
`define CDQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked property, also sampled during reset
`define CDQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`else

`define CDQ_ASSERT(lbl, prop, msg)
`define CDQ_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

@@ rtl/core/cdq_pkg.sv @@
// shared types, constants and index helpers for the circular deque
// no dependencies
`timescale 1ns / 1ps

package cdq_pkg;

  localparam int unsigned Depth = 16;
  localparam int unsigned DataW = 32;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  localparam logic [AddrW-1:0] LastIdx = AddrW'(Depth - 1);

  typedef enum logic [1:0] {
    CMD_PUSH_BACK  = 2'd0,
    CMD_PUSH_FRONT = 2'd1,
    CMD_POP_FRONT  = 2'd2,
    CMD_POP_BACK   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // result held while the store read is in flight
  typedef struct packed {
    status_e         status;
    logic            pop_ok;
    logic [CntW-1:0] occupancy;
  } result_t;

  // step forward with wrap at the depth
  function automatic logic [AddrW-1:0] wrap_inc(logic [AddrW-1:0] idx);
    return (idx == LastIdx) ? '0 : idx + AddrW'(1);
  endfunction

  // step back with wrap at the depth
  function automatic logic [AddrW-1:0] wrap_dec(logic [AddrW-1:0] idx);
    return (idx == '0) ? LastIdx : idx - AddrW'(1);
  endfunction

endpackage

@@ rtl/core/cdq_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module cdq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/circular_deque.sv @@
// top level of the circular deque: index control, result registers
// depends on cdq_pkg, cdq_ram and assert_macros.svh
//
//  channel | signals                                        | dir
//  --------+------------------------------------------------+-----
//  in      | in_valid_i in_ready_o cmd_i push_value_i         | in
//  out     | out_valid_o out_ready_i status_o popped_value_o  | out
//          | occupancy_o                                    |
//
// a command first updates the indices and issues the store access, then the
// registered store read returns; the next command is
// taken once the result has moved into the output register and that register
// is free or being drained. no clearing pass after reset: the store is only
// read at entries a push has written. a stalled output holds off new beats.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module circular_deque import cdq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [31:0] push_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [31:0] popped_value_o,
  output logic [4:0]  occupancy_o
);

  logic [AddrW-1:0] head_q, head_d;
  logic [AddrW-1:0] tail_q, tail_d;
  logic             empty_q, empty_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  logic             pend_q;
  result_t          pend_res_q, res_d;

  logic             out_valid_q;
  status_e          out_status_q;
  logic [DataW-1:0] out_value_q;
  logic [CntW-1:0]  out_occ_q;

  logic             in_fire;
  logic             full;
  logic             ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  logic [DataW-1:0] ram_rdata;
  cmd_e             cmd;

  assign cmd     = cmd_e'(cmd_i);
  assign in_fire = in_valid_i & in_ready_o;
  assign full    = !empty_q && (wrap_inc(tail_q) == head_q);

  // one command in flight; output register must be free or draining
  assign in_ready_o = !pend_q && (!out_valid_q || out_ready_i);

  // command decode and index update
  always_comb begin
    head_d    = head_q;
    tail_d    = tail_q;
    empty_d   = empty_q;
    cnt_d     = cnt_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = '0;
    ram_raddr = head_q;
    res_d     = '{status: ST_DONE, pop_ok: 1'b0, occupancy: cnt_q};
    if (in_fire) begin
      unique case (cmd) inside
        CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
          if (empty_q) begin
            head_d  = '0;
            tail_d  = '0;
            empty_d = 1'b0;
            cnt_d   = CntW'(1);
            ram_we  = 1'b1;
          end else if (full) begin
            res_d.status = ST_FULL;
          end else begin
            ram_we = 1'b1;
            cnt_d  = cnt_q + CntW'(1);
            if (cmd == CMD_PUSH_BACK) begin
              tail_d    = wrap_inc(tail_q);
              ram_waddr = wrap_inc(tail_q);
            end else begin
              head_d    = wrap_dec(head_q);
              ram_waddr = wrap_dec(head_q);
            end
          end
        end
        CMD_POP_FRONT, CMD_POP_BACK: begin
          if (empty_q) begin
            res_d.status = ST_EMPTY;
          end else begin
            ram_re       = 1'b1;
            res_d.pop_ok = 1'b1;
            ram_raddr    = (cmd == CMD_POP_FRONT) ? head_q : tail_q;
            cnt_d        = cnt_q - CntW'(1);
            if (head_q == tail_q) begin
              empty_d = 1'b1;
              head_d  = '0;
              tail_d  = '0;
            end else if (cmd == CMD_POP_FRONT) begin
              head_d = wrap_inc(head_q);
            end else begin
              tail_d = wrap_dec(tail_q);
            end
          end
        end
        default: begin
        end
      endcase
    end
    res_d.occupancy = cnt_d;
  end

  // store of deque words
  cdq_ram #(
    .Width (DataW),
    .Depth (Depth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (push_value_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // index and fill state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      empty_q <= 1'b1;
      cnt_q   <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      empty_q <= empty_d;
      cnt_q   <= cnt_d;
    end
  end

  // pending flag and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q <= in_fire;
      if (pend_q) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, read data joins in the cycle after the beat
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      pend_res_q <= res_d;
    end
    if (pend_q) begin
      out_status_q <= pend_res_q.status;
      out_value_q  <= pend_res_q.pop_ok ? ram_rdata : '0;
      out_occ_q    <= pend_res_q.occupancy;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign popped_value_o = out_value_q;
  assign occupancy_o    = out_occ_q;

  // fill count stays in range and agrees with the empty flag
  `CDQ_ASSERT(a_cnt_range, cnt_q <= CntW'(Depth), "fill count above depth")
  `CDQ_ASSERT(a_empty_cnt, empty_q == (cnt_q == '0), "empty flag and count disagree")
  // a pending result lands in the output register next cycle
  `CDQ_ASSERT(a_pend_out, pend_q |=> out_valid_q, "pending result not presented")
  // a pop on an empty deque reports empty and changes nothing
  `CDQ_ASSERT(a_pop_empty,
              (in_fire && empty_q && (cmd == CMD_POP_FRONT || cmd == CMD_POP_BACK))
              |=> (pend_res_q.status == ST_EMPTY && empty_q),
              "empty pop mishandled")
  // a beat is never taken while a store read is outstanding
  `CDQ_ASSERT(a_one_flight, pend_q |-> !in_fire, "second beat while read in flight")

endmodule

@@ tb/sv/circular_deque_test.sv @@
// self-checking testbench for circular_deque: directed and random command beats
// depends on cdq_pkg and the circular_deque rtl; shadow deque model held locally
`timescale 1ns / 1ps

module circular_deque_test;
  import cdq_pkg::*;

  typedef struct packed {
    status_e          status;
    logic [DataW-1:0] popped;
    logic [4:0]       occ;
  } deque_result_t;

  logic              clk_i        = 1'b0;
  logic              rst_ni       = 1'b0;
  logic              in_valid_i   = 1'b0;
  logic              in_ready_o;
  logic [1:0]        cmd_i        = CMD_PUSH_BACK;
  logic [31:0]       push_value_i = '0;
  logic              out_valid_o;
  logic              out_ready_i  = 1'b0;
  logic [1:0]        status_o;
  logic [31:0]       popped_value_o;
  logic [4:0]        occupancy_o;

  // shadow deque state
  logic [DataW-1:0]  shadow_words [Depth];
  logic [AddrW-1:0]  shadow_front;
  logic [AddrW-1:0]  shadow_back;
  logic              shadow_empty;

  deque_result_t     awaited_results [$];
  deque_result_t     oldest_result;

  int unsigned       send_idle_pct = 0;
  int unsigned       recv_idle_pct = 0;
  int unsigned       mismatch_count = 0;
  int unsigned       beats_sent = 0;
  int unsigned       beats_checked = 0;
  int unsigned       pops_done = 0;
  int unsigned       full_rejects = 0;
  int unsigned       empty_rejects = 0;

  circular_deque DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .cmd_i          (cmd_i),
    .push_value_i   (push_value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .popped_value_o (popped_value_o),
    .occupancy_o    (occupancy_o)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // receiver back-pressure
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // index steps with wrap at the depth
  function automatic logic [AddrW-1:0] step_fwd(logic [AddrW-1:0] idx);
    return (int'(idx) + 1 == int'(Depth)) ? '0 : idx + 1'b1;
  endfunction

  function automatic logic [AddrW-1:0] step_back(logic [AddrW-1:0] idx);
    return (idx == '0) ? AddrW'(Depth - 1) : idx - 1'b1;
  endfunction

  task automatic shadow_clear();
    shadow_front = '0;
    shadow_back  = '0;
    shadow_empty = 1'b1;
  endtask

  // apply one command to the shadow deque and return what the block should answer
  function automatic deque_result_t deque_predict(cmd_e op, logic [DataW-1:0] word);
    deque_result_t r;
    r.status = ST_DONE;
    r.popped = '0;
    if (op == CMD_PUSH_BACK || op == CMD_PUSH_FRONT) begin
      if (shadow_empty) begin
        // first word always lands at entry 0
        shadow_front    = '0;
        shadow_back     = '0;
        shadow_empty    = 1'b0;
        shadow_words[0] = word;
      end else if (step_fwd(shadow_back) == shadow_front) begin
        r.status = ST_FULL;
      end else if (op == CMD_PUSH_BACK) begin
        shadow_back = step_fwd(shadow_back);
        shadow_words[shadow_back] = word;
      end else begin
        shadow_front = step_back(shadow_front);
        shadow_words[shadow_front] = word;
      end
    end else if (shadow_empty) begin
      r.status = ST_EMPTY;
    end else begin
      r.popped = (op == CMD_POP_FRONT) ? shadow_words[shadow_front]
                                       : shadow_words[shadow_back];
      if (shadow_front == shadow_back) begin
        // last word gone
        shadow_empty = 1'b1;
        shadow_front = '0;
        shadow_back  = '0;
      end else if (op == CMD_POP_FRONT) begin
        shadow_front = step_fwd(shadow_front);
      end else begin
        shadow_back = step_back(shadow_back);
      end
    end
    r.occ = shadow_empty ? 5'd0 :
            5'((int'(shadow_back) + int'(Depth) - int'(shadow_front)) % int'(Depth) + 1);
    return r;
  endfunction

  task automatic note_mismatch(string field, logic [31:0] want, logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch on %s at %0t: expected %h, got %h", field, $realtime, want, got);
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_results.size() == 0) begin
        note_mismatch("unexpected result beat", '0, {30'd0, status_o});
      end else begin
        oldest_result = awaited_results.pop_front();
        beats_checked++;
        if (status_o !== oldest_result.status)
          note_mismatch("status", 32'(oldest_result.status), 32'(status_o));
        if (popped_value_o !== oldest_result.popped)
          note_mismatch("popped_value", oldest_result.popped, popped_value_o);
        if (occupancy_o !== oldest_result.occ)
          note_mismatch("occupancy", 32'(oldest_result.occ), 32'(occupancy_o));
        case (oldest_result.status)
          ST_FULL:  full_rejects++;
          ST_EMPTY: empty_rejects++;
          default:  ;
        endcase
      end
    end
  end

  // send one command beat, holding valid until it is taken
  task automatic send_cmd(cmd_e op, logic [31:0] word);
    deque_result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i   <= 1'b1;
    cmd_i        <= op;
    push_value_i <= word;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = deque_predict(op, word);
    awaited_results.push_back(predicted);
    beats_sent++;
    if ((op == CMD_POP_FRONT || op == CMD_POP_BACK) && predicted.status == ST_DONE)
      pops_done++;
  endtask

  // sender pause until every awaited result has arrived or the cap is reached
  task automatic wait_all_results(int unsigned cap);
    int unsigned n;
    n = 0;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (awaited_results.size() != 0 && n < cap) begin
      @(posedge clk_i);
      n++;
    end
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(7))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'hffff_ffff;
      3:       return 32'h0000_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic cmd_e pick_push();
    return $urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
  endfunction

  function automatic cmd_e pick_pop();
    return $urandom_range(1) ? CMD_POP_FRONT : CMD_POP_BACK;
  endfunction

  // pops on the empty store from both ends
  task automatic test_empty_rejects();
    send_cmd(CMD_POP_FRONT, 32'hdead_beef);
    send_cmd(CMD_POP_BACK,  32'h0123_4567);
  endtask

  // single word: front push on empty lands at entry 0, pop of last word empties
  task automatic test_single_word();
    send_cmd(CMD_PUSH_FRONT, 32'ha5a5_5a5a);
    send_cmd(CMD_POP_BACK,   32'h0);
    send_cmd(CMD_PUSH_BACK,  32'h7fff_ffff);
    send_cmd(CMD_POP_FRONT,  32'hffff_ffff);
    send_cmd(CMD_POP_FRONT,  32'h0);
  endtask

  // value extremes at both ends, front index wraps below zero
  task automatic test_value_extremes();
    send_cmd(CMD_PUSH_BACK,  32'h8000_0000);
    send_cmd(CMD_PUSH_FRONT, 32'hffff_ffff);
    send_cmd(CMD_PUSH_BACK,  32'h0000_0000);
    send_cmd(CMD_PUSH_FRONT, 32'h7fff_ffff);
    send_cmd(CMD_POP_FRONT,  32'h5555_5555);
    send_cmd(CMD_POP_BACK,   32'haaaa_aaaa);
    send_cmd(CMD_POP_FRONT,  32'h0);
    send_cmd(CMD_POP_BACK,   32'h0);
    send_cmd(CMD_POP_BACK,   32'hffff_ffff);
  endtask

  // fill past full and drain past empty, random ends and words
  task automatic test_fill_and_drain();
    repeat (Depth + 2) send_cmd(pick_push(), pick_word());
    repeat (Depth + 2) send_cmd(pick_pop(), $urandom());
  endtask

  // random bursts leaning towards filling, draining or neither
  task automatic test_random_traffic(int unsigned n_beats);
    int unsigned sent;
    int unsigned push_pct;
    int unsigned burst;
    sent = 0;
    while (sent < n_beats) begin
      case ($urandom_range(2))
        0:       push_pct = 80;
        1:       push_pct = 20;
        default: push_pct = 50;
      endcase
      burst = $urandom_range(40, 8);
      repeat (burst) begin
        if ($urandom_range(99) < push_pct) send_cmd(pick_push(), pick_word());
        else                               send_cmd(pick_pop(), $urandom());
        sent++;
      end
    end
  endtask

  // overall time limit
  initial begin
    #5_000_000;
    $display("[circular_deque] ERROR");
    $finish;
  end

  initial begin
    shadow_clear();
    send_idle_pct = 28;
    recv_idle_pct = 68;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_rejects();
    test_single_word();
    test_value_extremes();
    test_fill_and_drain();
    test_random_traffic(220);
    wait_all_results(20000);

    send_idle_pct = 68;
    recv_idle_pct = 28;
    test_random_traffic(220);
    wait_all_results(20000);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(220);

    // final drain and settle
    wait_all_results(20000);
    repeat (10) @(posedge clk_i);
    if (awaited_results.size() != 0) begin
      $display("%0d results never arrived", awaited_results.size());
      mismatch_count += awaited_results.size();
    end

    $display("%0d command beats sent, %0d results checked, %0d mismatches",
             beats_sent, beats_checked, mismatch_count);
    $display("covered %0d pops, %0d full and %0d empty rejects under three idling mixes",
             pops_done, full_rejects, empty_rejects);
    if (mismatch_count == 0) begin
      $display("[circular_deque] OK");
    end else begin
      $display("[circular_deque] ERROR");
    end
    $finish;
  end

endmodule
